>>> rtl/fam_pkg.sv
// ----------------------------------------------------------------------------
// fam_pkg
// Shared constants, codes and controller/datapath interface types of the
// paged flash array model.
// ----------------------------------------------------------------------------
package fam_pkg;

    localparam int MAX_PAGE_BYTES = 4096;
    localparam int MAX_PAGES      = 16;
    localparam int READ_BURST     = 64;

    localparam int ARRAY_SIZE = MAX_PAGE_BYTES * MAX_PAGES;
    localparam int ADDR_W     = $clog2(ARRAY_SIZE);
    localparam int SIZE_W     = ADDR_W + 1;
    localparam int PB_W       = 13;
    localparam int PG_W       = 5;
    localparam int PIDX_W     = $clog2(MAX_PAGES);
    localparam int RC_W       = $clog2(READ_BURST + 1);
    localparam int LEN_W      = 16;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        OP_READ         = 3'd0,
        OP_WRITE        = 3'd1,
        OP_ERASE_PAGE   = 3'd2,
        OP_ERASE_SECTOR = 3'd3,
        OP_ERASE_ALL    = 3'd4,
        OP_QUERY        = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_ALIGN = 2'd2,
        ST_FAIL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_PAGE_BYTES  = 2'd0,
        CFG_PAGES       = 2'd1,
        CFG_WRITE_UNIT  = 2'd2,
        CFG_AUTO_ERASE  = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        SRCH_INDEX,
        SRCH_ADDR,
        SRCH_SPAN_END
    } search_sel_t;

    typedef enum logic [1:0] {
        SW_PAGE,
        SW_ALL,
        SW_AE,
        SW_CLEAR
    } sweep_sel_t;

    typedef enum logic [1:0] {
        MK_NONE,
        MK_SET_SEARCH,
        MK_SET_AE,
        MK_SET_ALL
    } mark_op_t;

    typedef enum logic [1:0] {
        RES_CONST,
        RES_READ,
        RES_QUERY,
        RES_ACCESS
    } res_src_t;

    typedef struct packed {
        logic        take;
        logic        search_init;
        logic        search_step;
        search_sel_t search_sel;
        logic        save_first;
        logic        save_last;
        logic        sweep_init;
        sweep_sel_t  sweep_sel;
        logic        sweep_step;
        mark_op_t    mark_op;
        logic        ae_advance;
        logic        wr_start;
        logic        wb_issue;
        logic        wb_commit;
        logic        wr_close;
        logic        rd_init;
        logic        rd_issue;
        logic        rd_next;
        logic        emit;
        res_src_t    emit_src;
        status_t     emit_st;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       start;
        logic       len_zero;
        logic       range_bad;
        logic       wip;
        logic       page_bad;
        logic       search_stop;
        logic       search_oor;
        logic       span_ok;
        logic       ae;
        logic       ae_done;
        logic       ae_dirty;
        logic       sweep_last;
        logic       rd_last;
        logic       wb_go;
        logic       out_free;
    } stat_t;

endpackage

>>> rtl/fam_ram.sv
// ----------------------------------------------------------------------------
// fam_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/fam_datapath.sv
// ----------------------------------------------------------------------------
// fam_datapath
// Configuration, access state, erased marks, page search, sweep address,
// byte array and output register of the flash array model.
// ----------------------------------------------------------------------------
module fam_datapath import fam_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [PB_W-1:0]   cfg_data,
    input  logic [2:0]        opcode,
    input  logic [LEN_W-1:0]  address,
    input  logic [LEN_W-1:0]  access_length,
    input  logic [7:0]        write_byte,
    input  logic              access_start,
    input  logic              access_end,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [7:0]        read_data,
    output logic              page_is_erased,
    output logic              last,
    input  cmd_t              cmd,
    output stat_t             stat
);

    // configuration
    logic [PB_W-1:0] pb_reg;
    logic [PG_W-1:0] pg_reg;
    logic [1:0]      wu_reg;
    logic            ae_reg;

    // latched request
    logic [2:0]       op_reg;
    logic [LEN_W-1:0] addr_reg;
    logic [LEN_W-1:0] len_reg;
    logic [7:0]       data_reg;
    logic             start_reg;
    logic             end_reg;

    // write access
    logic              wip_reg;
    status_t           ast_reg;
    logic [PIDX_W-1:0] first_pg_reg;
    logic [PIDX_W-1:0] last_pg_reg;
    logic [LEN_W-1:0]  wbase_reg;
    logic [LEN_W-1:0]  wlen_reg;
    logic [LEN_W-1:0]  wcnt_reg;
    logic [ADDR_W-1:0] wa_reg;
    logic              wa_ok_reg;

    logic [MAX_PAGES-1:0] marks_reg;

    // page search and auto-erase walk
    logic [PG_W-1:0]   scnt_reg;
    logic [SIZE_W-1:0] sbase_reg;
    logic [PG_W-1:0]   ppg_reg;
    logic [SIZE_W-1:0] pbase_reg;

    // sweep
    logic [SIZE_W-1:0] ptr_reg;
    logic [SIZE_W-1:0] end_ptr_reg;

    logic [RC_W-1:0] rcnt_reg;

    logic       out_valid_reg;
    logic [1:0] status_reg;
    logic [7:0] read_data_reg;
    logic       pe_reg;
    logic       last_reg;

    // combinational
    logic [PB_W-1:0]        eff_pb;
    logic [PG_W-1:0]        eff_pg;
    logic [PB_W+PG_W-1:0]   prod;
    logic [SIZE_W-1:0]      total;
    logic [SIZE_W-1:0]      addr_x;
    logic [SIZE_W-1:0]      len_x;
    logic [SIZE_W-1:0]      end_x;
    logic                   range_bad;
    logic [3:0]             unit_mask;
    logic                   misaligned;
    logic                   len_zero;
    status_t                start_code;
    logic [SIZE_W-1:0]      search_v;
    logic [SIZE_W:0]        step_sum;
    logic                   search_stop;
    logic [SIZE_W-1:0]      wr_a;
    logic                   wb_go;
    logic [RC_W-1:0]        rd_n;
    logic                   rd_last;
    logic                   sweep_last;
    logic [SIZE_W-1:0]      ptr_inc;
    logic                   out_free;
    logic [7:0]             ram_rdata;
    logic                   ram_wr_en;
    logic [ADDR_W-1:0]      ram_wr_addr;
    logic [7:0]             ram_wr_data;
    logic                   ram_rd_en;
    logic [ADDR_W-1:0]      ram_rd_addr;
    logic [7:0]             merged;
    logic                   wb_fail;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (pb_reg == '0)
            eff_pb = PB_W'(1);
        else if (pb_reg > PB_W'(MAX_PAGE_BYTES))
            eff_pb = PB_W'(MAX_PAGE_BYTES);
        else
            eff_pb = pb_reg;
        if (pg_reg == '0)
            eff_pg = PG_W'(1);
        else if (pg_reg > PG_W'(MAX_PAGES))
            eff_pg = PG_W'(MAX_PAGES);
        else
            eff_pg = pg_reg;
        case (wu_reg)
            2'd0:    unit_mask = 4'd3;
            2'd1:    unit_mask = 4'd7;
            default: unit_mask = 4'd15;
        endcase
    end

    assign prod  = {{PG_W{1'b0}}, eff_pb} * {{PB_W{1'b0}}, eff_pg};
    assign total = prod[SIZE_W-1:0];

    assign addr_x     = {1'b0, addr_reg};
    assign len_x      = {1'b0, len_reg};
    assign end_x      = addr_x + len_x;
    assign range_bad  = (addr_x >= total) || (end_x > total);
    assign misaligned = ((addr_reg[3:0] & unit_mask) != 4'd0)
                     || ((len_reg[3:0] & unit_mask) != 4'd0);
    assign len_zero   = (len_reg == '0);

    always_comb
    begin
        if (len_zero)
            start_code = ST_OK;
        else if (range_bad)
            start_code = ST_RANGE;
        else if (misaligned)
            start_code = ST_ALIGN;
        else
            start_code = ST_OK;
    end

    // page search: walk page bases until the next base passes the target, the index is reached or pages run out
    always_comb
    begin
        case (cmd.search_sel)
            SRCH_ADDR:     search_v = addr_x;
            SRCH_SPAN_END: search_v = end_x - SIZE_W'(1);
            default:       search_v = '0;
        endcase
    end

    assign step_sum = {1'b0, sbase_reg} + {{(SIZE_W+1-PB_W){1'b0}}, eff_pb};

    always_comb
    begin
        if (scnt_reg == eff_pg)
            search_stop = 1'b1;
        else if (cmd.search_sel == SRCH_INDEX)
            search_stop = ({{(LEN_W-PG_W){1'b0}}, scnt_reg} == addr_reg);
        else
            search_stop = (step_sum > {1'b0, search_v});
    end

    // a byte past the array end still uses up its slot of the access
    assign wr_a  = {1'b0, wbase_reg} + {1'b0, wcnt_reg};
    assign wb_go = (ast_reg == ST_OK) && (wcnt_reg < wlen_reg);

    assign rd_n    = (len_reg > LEN_W'(READ_BURST)) ? RC_W'(READ_BURST) : len_reg[RC_W-1:0];
    assign rd_last = (RC_W'(rcnt_reg + RC_W'(1)) == rd_n);

    assign ptr_inc    = ptr_reg + SIZE_W'(1);
    assign sweep_last = (ptr_inc == end_ptr_reg);

    assign out_free = !out_valid_reg || !out_stall;

    assign merged  = ram_rdata & data_reg;
    assign wb_fail = wa_ok_reg && (merged != data_reg) && !ae_reg;

    always_comb
    begin
        stat.op          = op_reg;
        stat.start       = start_reg;
        stat.len_zero    = len_zero;
        stat.range_bad   = range_bad;
        stat.wip         = wip_reg;
        stat.page_bad    = (addr_reg >= {{(LEN_W-PG_W){1'b0}}, eff_pg});
        stat.search_stop = search_stop;
        stat.search_oor  = (scnt_reg == eff_pg);
        stat.span_ok     = !len_zero && !range_bad && !misaligned;
        stat.ae          = ae_reg;
        stat.ae_done     = (ppg_reg > {1'b0, last_pg_reg});
        stat.ae_dirty    = !marks_reg[ppg_reg[PIDX_W-1:0]];
        stat.sweep_last  = sweep_last;
        stat.rd_last     = rd_last;
        stat.wb_go       = wb_go;
        stat.out_free    = out_free;
    end

    // RAM port selection
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = ptr_reg[ADDR_W-1:0];
        ram_wr_data = ERASED_BYTE;
        if (cmd.sweep_step)
        begin
            ram_wr_en = 1'b1;
        end
        else if (cmd.wb_commit && wa_ok_reg && !wb_fail)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wa_reg;
            ram_wr_data = merged;
        end
        ram_rd_en   = cmd.rd_issue || cmd.wb_issue;
        if (cmd.wb_issue)
            ram_rd_addr = wr_a[ADDR_W-1:0];
        else
            ram_rd_addr = ADDR_W'(addr_x + {{(SIZE_W-RC_W){1'b0}}, rcnt_reg});
    end

    fam_ram #(
        .WIDTH (8),
        .DEPTH (ARRAY_SIZE)
    ) u_array (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pb_reg        <= PB_W'(MAX_PAGE_BYTES);
            pg_reg        <= PG_W'(MAX_PAGES);
            wu_reg        <= 2'd0;
            ae_reg        <= 1'b0;
            wip_reg       <= 1'b0;
            ast_reg       <= ST_OK;
            first_pg_reg  <= '0;
            last_pg_reg   <= '0;
            marks_reg     <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_PAGE_BYTES: pb_reg <= cfg_data;
                    CFG_PAGES:      pg_reg <= cfg_data[PG_W-1:0];
                    CFG_WRITE_UNIT: wu_reg <= cfg_data[1:0];
                    CFG_AUTO_ERASE: ae_reg <= cfg_data[0];
                    default:        ;
                endcase
            end

            if (cmd.wr_start)
            begin
                wip_reg      <= 1'b1;
                ast_reg      <= start_code;
                first_pg_reg <= '0;
                last_pg_reg  <= '0;
            end
            if (cmd.save_first)
                first_pg_reg <= scnt_reg[PIDX_W-1:0];
            if (cmd.save_last)
                last_pg_reg <= scnt_reg[PIDX_W-1:0];
            if (cmd.wb_commit && wb_fail)
                ast_reg <= ST_FAIL;

            case (cmd.mark_op)
                MK_SET_SEARCH: marks_reg[scnt_reg[PIDX_W-1:0]] <= 1'b1;
                MK_SET_AE:     marks_reg[ppg_reg[PIDX_W-1:0]] <= 1'b1;
                MK_SET_ALL:
                begin
                    for (int p = 0; p < MAX_PAGES; p++)
                    begin
                        if (PG_W'(p) < eff_pg)
                            marks_reg[p] <= 1'b1;
                    end
                end
                default: ;
            endcase

            // close the access; a clean one dirties its span
            if (cmd.wr_close && end_reg)
            begin
                wip_reg <= 1'b0;
                if (ast_reg == ST_OK && wlen_reg != '0)
                begin
                    for (int p = 0; p < MAX_PAGES; p++)
                    begin
                        if (PIDX_W'(p) >= first_pg_reg && PIDX_W'(p) <= last_pg_reg)
                            marks_reg[p] <= 1'b0;
                    end
                end
            end

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg    <= opcode;
            addr_reg  <= address;
            len_reg   <= access_length;
            data_reg  <= write_byte;
            start_reg <= access_start;
            end_reg   <= access_end;
        end
        if (cmd.wr_start)
        begin
            wbase_reg <= addr_reg;
            wlen_reg  <= len_reg;
            wcnt_reg  <= '0;
        end
        if (cmd.wb_issue)
        begin
            wa_reg    <= wr_a[ADDR_W-1:0];
            wa_ok_reg <= (wr_a < total);
            wcnt_reg  <= wcnt_reg + LEN_W'(1);
        end

        if (cmd.search_init)
        begin
            scnt_reg  <= '0;
            sbase_reg <= '0;
        end
        else if (cmd.search_step)
        begin
            scnt_reg  <= scnt_reg + PG_W'(1);
            sbase_reg <= step_sum[SIZE_W-1:0];
        end

        if (cmd.save_first)
            pbase_reg <= sbase_reg;
        if (cmd.save_last)
            ppg_reg <= {1'b0, first_pg_reg};
        if (cmd.ae_advance)
        begin
            ppg_reg   <= ppg_reg + PG_W'(1);
            pbase_reg <= pbase_reg + {{(SIZE_W-PB_W){1'b0}}, eff_pb};
        end

        if (cmd.sweep_init)
        begin
            case (cmd.sweep_sel)
                SW_PAGE:
                begin
                    ptr_reg     <= sbase_reg;
                    end_ptr_reg <= sbase_reg + {{(SIZE_W-PB_W){1'b0}}, eff_pb};
                end
                SW_ALL:
                begin
                    ptr_reg     <= '0;
                    end_ptr_reg <= total;
                end
                SW_AE:
                begin
                    ptr_reg     <= pbase_reg;
                    end_ptr_reg <= pbase_reg + {{(SIZE_W-PB_W){1'b0}}, eff_pb};
                end
                default:
                begin
                    ptr_reg     <= '0;
                    end_ptr_reg <= SIZE_W'(ARRAY_SIZE);
                end
            endcase
        end
        else if (cmd.sweep_step)
        begin
            ptr_reg <= ptr_inc;
        end

        if (cmd.rd_init)
            rcnt_reg <= '0;
        else if (cmd.rd_next)
            rcnt_reg <= rcnt_reg + RC_W'(1);

        if (cmd.emit)
        begin
            status_reg    <= (cmd.emit_src == RES_ACCESS) ? ast_reg : cmd.emit_st;
            read_data_reg <= (cmd.emit_src == RES_READ) ? ram_rdata : 8'd0;
            pe_reg        <= (cmd.emit_src == RES_QUERY)
                             ? marks_reg[addr_reg[PIDX_W-1:0]] : 1'b0;
            last_reg      <= (cmd.emit_src == RES_READ) ? rd_last : 1'b1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign read_data      = read_data_reg;
    assign page_is_erased = pe_reg;
    assign last           = last_reg;

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result loaded while output register is stalled");

    a_commit_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wb_commit |-> $past(cmd.wb_issue))
        else $error("byte commit without its read");

    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep_step |-> !cmd.wb_commit)
        else $error("sweep and byte commit share the write port");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> !(cmd.sweep_step || cmd.search_step || cmd.wb_issue))
        else $error("request taken while work is in flight");

endmodule

>>> rtl/fam_ctrl.sv
// ----------------------------------------------------------------------------
// fam_ctrl
// Sequencer of the flash array model: decodes a request and steps the
// datapath through search, sweep, read-modify-write and result phases.
// ----------------------------------------------------------------------------
module fam_ctrl import fam_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_CLR_INIT,
        S_CLR_SWEEP,
        S_IDLE,
        S_DECODE,
        S_SEARCH_PG,
        S_SEARCH_SEC,
        S_PG_SWEEP,
        S_ALL_SWEEP,
        S_SPAN_FIRST,
        S_SPAN_LAST,
        S_AE_CHECK,
        S_AE_SWEEP,
        S_WB_ISSUE,
        S_WB_COMMIT,
        S_EMIT_W,
        S_RD_ISSUE,
        S_RD_EMIT,
        S_EMIT_OK,
        S_EMIT_RANGE,
        S_EMIT_FAIL,
        S_EMIT_Q
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLR_INIT:
            begin
                cmd.sweep_init = 1'b1;
                cmd.sweep_sel  = SW_CLEAR;
                state_next     = S_CLR_SWEEP;
            end
            S_CLR_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_READ:
                    begin
                        if (stat.len_zero)
                            state_next = S_EMIT_OK;
                        else if (stat.range_bad)
                            state_next = S_EMIT_RANGE;
                        else
                        begin
                            cmd.rd_init = 1'b1;
                            state_next  = S_RD_ISSUE;
                        end
                    end
                    OP_WRITE:
                    begin
                        if (stat.start)
                        begin
                            cmd.wr_start    = 1'b1;
                            cmd.search_init = 1'b1;
                            state_next = stat.span_ok ? S_SPAN_FIRST : S_WB_ISSUE;
                        end
                        else if (!stat.wip)
                            state_next = S_EMIT_FAIL;
                        else
                            state_next = S_WB_ISSUE;
                    end
                    OP_ERASE_PAGE:
                    begin
                        if (stat.page_bad)
                            state_next = S_EMIT_RANGE;
                        else
                        begin
                            cmd.search_init = 1'b1;
                            state_next      = S_SEARCH_PG;
                        end
                    end
                    OP_ERASE_SECTOR:
                    begin
                        cmd.search_init = 1'b1;
                        state_next      = S_SEARCH_SEC;
                    end
                    OP_ERASE_ALL:
                    begin
                        cmd.sweep_init = 1'b1;
                        cmd.sweep_sel  = SW_ALL;
                        state_next     = S_ALL_SWEEP;
                    end
                    OP_QUERY:
                    begin
                        state_next = stat.page_bad ? S_EMIT_RANGE : S_EMIT_Q;
                    end
                    default:
                    begin
                        state_next = S_EMIT_OK;
                    end
                endcase
            end
            S_SEARCH_PG:
            begin
                cmd.search_sel = SRCH_INDEX;
                if (stat.search_stop)
                begin
                    cmd.sweep_init = 1'b1;
                    cmd.sweep_sel  = SW_PAGE;
                    state_next     = S_PG_SWEEP;
                end
                else
                    cmd.search_step = 1'b1;
            end
            S_SEARCH_SEC:
            begin
                cmd.search_sel = SRCH_ADDR;
                if (stat.search_stop)
                begin
                    if (stat.search_oor)
                        state_next = S_EMIT_RANGE;
                    else
                    begin
                        cmd.sweep_init = 1'b1;
                        cmd.sweep_sel  = SW_PAGE;
                        state_next     = S_PG_SWEEP;
                    end
                end
                else
                    cmd.search_step = 1'b1;
            end
            S_PG_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.mark_op = MK_SET_SEARCH;
                    state_next  = S_EMIT_OK;
                end
            end
            S_ALL_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.mark_op = MK_SET_ALL;
                    state_next  = S_EMIT_OK;
                end
            end
            S_SPAN_FIRST:
            begin
                cmd.search_sel = SRCH_ADDR;
                if (stat.search_stop)
                begin
                    cmd.save_first = 1'b1;
                    state_next     = S_SPAN_LAST;
                end
                else
                    cmd.search_step = 1'b1;
            end
            S_SPAN_LAST:
            begin
                // continue from the first page; the span end never lies below it
                cmd.search_sel = SRCH_SPAN_END;
                if (stat.search_stop)
                begin
                    cmd.save_last = 1'b1;
                    state_next    = stat.ae ? S_AE_CHECK : S_WB_ISSUE;
                end
                else
                    cmd.search_step = 1'b1;
            end
            S_AE_CHECK:
            begin
                if (stat.ae_done)
                    state_next = S_WB_ISSUE;
                else if (stat.ae_dirty)
                begin
                    cmd.sweep_init = 1'b1;
                    cmd.sweep_sel  = SW_AE;
                    state_next     = S_AE_SWEEP;
                end
                else
                    cmd.ae_advance = 1'b1;
            end
            S_AE_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.mark_op    = MK_SET_AE;
                    cmd.ae_advance = 1'b1;
                    state_next     = S_AE_CHECK;
                end
            end
            S_WB_ISSUE:
            begin
                if (stat.wb_go)
                begin
                    cmd.wb_issue = 1'b1;
                    state_next   = S_WB_COMMIT;
                end
                else
                    state_next = S_EMIT_W;
            end
            S_WB_COMMIT:
            begin
                cmd.wb_commit = 1'b1;
                state_next    = S_EMIT_W;
            end
            S_EMIT_W:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = RES_ACCESS;
                    cmd.wr_close = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RD_EMIT;
            end
            S_RD_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = RES_READ;
                    cmd.emit_st  = ST_OK;
                    cmd.rd_next  = 1'b1;
                    state_next   = stat.rd_last ? S_IDLE : S_RD_ISSUE;
                end
            end
            S_EMIT_OK, S_EMIT_RANGE, S_EMIT_FAIL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = RES_CONST;
                    if (state_reg == S_EMIT_RANGE)
                        cmd.emit_st = ST_RANGE;
                    else if (state_reg == S_EMIT_FAIL)
                        cmd.emit_st = ST_FAIL;
                    else
                        cmd.emit_st = ST_OK;
                    state_next = S_IDLE;
                end
            end
            S_EMIT_Q:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = RES_QUERY;
                    cmd.emit_st  = ST_OK;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLR_INIT;
        else
            state_reg <= state_next;
    end

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR_SWEEP) |-> in_stall)
        else $error("request accepted during clearing pass");

    a_take_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> (state_reg == S_DECODE))
        else $error("accepted request not decoded");

    a_commit_then_report: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB_COMMIT) |=> (state_reg == S_EMIT_W))
        else $error("byte commit not followed by its result");

endmodule

>>> rtl/flash_array_model_unit.sv
// ----------------------------------------------------------------------------
// flash_array_model_unit
// Paged NOR-style flash array model: byte reads, streamed byte writes with
// range/alignment checks and optional auto-erase, page/sector/full erase and
// a page-erased query.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the 65536-byte array, one
// byte a cycle, and holds in_stall high until it is done; configuration
// writes are taken at any time. Requests are handled one at a time by a
// sequencer over a single-port-write, single-port-read byte RAM. A request
// is accepted, then decoded, then: each read result takes a RAM read, then
// an output load, up to 64 results; a write byte may take a read-modify-write
// and then gives its result. A start item with a valid span adds two
// page-table walks and, with auto-erase on, a check of each page of its span
// and a sweep of each dirty page. Page and sector erase search the page
// table, then sweep the page; full erase sweeps every byte of the pages in
// use. A waiting result in the output register does not block acceptance
// of the next request.
// ----------------------------------------------------------------------------
module flash_array_model_unit import fam_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [15:0] address,
    input  logic [15:0] access_length,
    input  logic [7:0]  write_byte,
    input  logic        access_start,
    input  logic        access_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  read_data,
    output logic        page_is_erased,
    output logic        last
);

    cmd_t  cmd;
    stat_t stat;

    fam_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    fam_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .opcode         (opcode),
        .address        (address),
        .access_length  (access_length),
        .write_byte     (write_byte),
        .access_start   (access_start),
        .access_end     (access_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .read_data      (read_data),
        .page_is_erased (page_is_erased),
        .last           (last),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

>>> tb/tb_flash_array_model_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_flash_array_model_unit
// Self-checking bench for the paged flash array model. It streams directed and
// random requests (reads, byte-streamed writes, erases and queries) over
// several page/unit/auto-erase settings. An in-bench predictor of the array
// computes every expected result, and each result is compared in order.
// ----------------------------------------------------------------------------
module tb_flash_array_model_unit;
    import fam_pkg::*;

    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    typedef struct {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [15:0] len;
        logic [7:0]  wb;
        logic        st;
        logic        en;
    } flash_req_t;

    typedef struct {
        logic [1:0] st;
        logic [7:0] rd;
        logic       pe;
        logic       lst;
    } flash_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  opcode = '0;
    logic [15:0] address = '0;
    logic [15:0] access_length = '0;
    logic [7:0]  write_byte = '0;
    logic        access_start = 1'b0;
    logic        access_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [7:0]  read_data;
    logic        page_is_erased;
    logic        last;

    flash_array_model_unit dut (.*);

    always #2 clk = ~clk;

    // predictor state
    logic [12:0] pb_reg = 13'd4096;
    logic [4:0]  pg_reg = 5'd16;
    logic [1:0]  unit_reg = 2'd0;
    logic        ae_reg = 1'b0;
    logic [7:0]  flash_img [ARRAY_SIZE];
    logic        erased_mark [MAX_PAGES];
    logic        wr_open = 1'b0;
    logic [1:0]  wr_status = ST_OK;
    int unsigned span_lo = 0, span_hi = 0, wr_base = 0, wr_len = 0, wr_count = 0;

    flash_req_t  pend_q [$];
    flash_res_t  expected_q [$];
    int          mismatches = 0;
    int          accepted = 0;
    logic        long_hold = 1'b0;

    initial
    begin
        foreach (flash_img[i]) flash_img[i] = ERASED_BYTE;
        foreach (erased_mark[i]) erased_mark[i] = 1'b1;
    end

    function automatic int unsigned bytes_per_page();
        if (pb_reg < 1) return 1;
        if (pb_reg > MAX_PAGE_BYTES) return MAX_PAGE_BYTES;
        return 32'(pb_reg);
    endfunction

    function automatic int unsigned pages_used();
        if (pg_reg < 1) return 1;
        if (pg_reg > MAX_PAGES) return MAX_PAGES;
        return 32'(pg_reg);
    endfunction

    function automatic int unsigned unit_size();
        if (unit_reg == 2'd0) return 4;
        if (unit_reg == 2'd1) return 8;
        return 16;
    endfunction

    function automatic void wipe_page(int unsigned p);
        int unsigned pb;
        pb = bytes_per_page();
        if (p >= pages_used()) return;
        for (int unsigned i = 0; i < pb; i++) flash_img[p * pb + i] = ERASED_BYTE;
        erased_mark[p] = 1'b1;
    endfunction

    function automatic void push_result(logic [1:0] st, logic [7:0] rd, logic pe, logic lst);
        flash_res_t r;
        r.st = st; r.rd = rd; r.pe = pe; r.lst = lst;
        expected_q.push_back(r);
    endfunction

    function automatic logic [1:0] program_byte(flash_req_t r);
        int unsigned total, u, a, pb;
        logic [7:0] cur;
        total = bytes_per_page() * pages_used();
        pb = bytes_per_page();
        if (r.st) begin
            u = unit_size();
            wr_open = 1'b1; wr_status = ST_OK;
            wr_base = 32'(r.addr); wr_len = 32'(r.len); wr_count = 0;
            span_lo = 0; span_hi = 0;
            if (r.len != 0) begin
                if (r.addr >= total || r.addr + r.len > total)
                    wr_status = ST_RANGE;
                else if ((r.addr & (u - 1)) != 0 || (r.len & (u - 1)) != 0)
                    wr_status = ST_ALIGN;
                else begin
                    span_lo = 32'(r.addr) / pb;
                    span_hi = (32'(r.addr) + 32'(r.len) - 1) / pb;
                    if (ae_reg)
                        for (int unsigned p = span_lo; p <= span_hi && p < MAX_PAGES; p++)
                            if (!erased_mark[p]) wipe_page(p);
                end
            end
        end
        else if (!wr_open)
            return ST_FAIL;

        if (wr_status == ST_OK && wr_count < wr_len) begin
            a = wr_base + wr_count;
            wr_count++;
            if (a < total && a < ARRAY_SIZE) begin
                cur = flash_img[a];
                if ((cur & r.wb) != r.wb && !ae_reg) wr_status = ST_FAIL;
                else flash_img[a] = cur & r.wb;
            end
        end
        program_byte = wr_status;
        if (r.en) begin
            if (wr_status == ST_OK && wr_len != 0)
                for (int unsigned p = span_lo; p <= span_hi && p < MAX_PAGES; p++)
                    erased_mark[p] = 1'b0;
            wr_open = 1'b0;
        end
    endfunction

    function automatic void predict_request(flash_req_t r);
        int unsigned pages, total, n, p;
        pages = pages_used();
        total = bytes_per_page() * pages;
        case (r.op)
            OP_READ:
            begin
                if (r.len == 0) push_result(ST_OK, 8'h00, 1'b0, 1'b1);
                else if (r.addr >= total || r.addr + r.len > total)
                    push_result(ST_RANGE, 8'h00, 1'b0, 1'b1);
                else
                begin
                    n = (r.len > READ_BURST) ? READ_BURST : 32'(r.len);
                    for (int unsigned i = 0; i < n; i++)
                        push_result(ST_OK, flash_img[32'(r.addr) + i], 1'b0, i + 1 == n);
                end
            end
            OP_WRITE: push_result(program_byte(r), 8'h00, 1'b0, 1'b1);
            OP_ERASE_PAGE, OP_ERASE_SECTOR:
            begin
                p = (r.op == OP_ERASE_PAGE) ? 32'(r.addr) : 32'(r.addr) / bytes_per_page();
                if (p >= pages) push_result(ST_RANGE, 8'h00, 1'b0, 1'b1);
                else
                begin
                    wipe_page(p);
                    push_result(ST_OK, 8'h00, 1'b0, 1'b1);
                end
            end
            OP_ERASE_ALL:
            begin
                for (int unsigned i = 0; i < total; i++) flash_img[i] = ERASED_BYTE;
                for (int unsigned i = 0; i < pages; i++) erased_mark[i] = 1'b1;
                push_result(ST_OK, 8'h00, 1'b0, 1'b1);
            end
            OP_QUERY:
            begin
                if (r.addr >= pages) push_result(ST_RANGE, 8'h00, 1'b0, 1'b1);
                else push_result(ST_OK, 8'h00, erased_mark[r.addr], 1'b1);
            end
            default: push_result(ST_OK, 8'h00, 1'b0, 1'b1);
        endcase
    endfunction

    // request driver
    int   in_wait = 0;
    logic in_calm = 1'b0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_request(pend_q.pop_front());
                accepted++;
                if ($urandom_range(0, 40) == 0) in_calm = ~in_calm;
                in_wait = in_calm ? 0 : $urandom_range(0, 10);
            end
            if ((in_valid && !in_stall) || !in_valid)
            begin
                if (in_wait == 0 && pend_q.size() > 0)
                begin
                    in_valid      <= 1'b1;
                    opcode        <= pend_q[0].op;
                    address       <= pend_q[0].addr;
                    access_length <= pend_q[0].len;
                    write_byte    <= pend_q[0].wb;
                    access_start  <= pend_q[0].st;
                    access_end    <= pend_q[0].en;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (in_wait > 0) in_wait--;
                end
            end
        end
    end

    // result monitor
    int   out_wait = 0;
    logic out_calm = 1'b0;
    always @(posedge clk)
    begin
        flash_res_t e;
        if (out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result st=%0d rd=%h", status, read_data);
            end
            else
            begin
                e = expected_q.pop_front();
                if (status !== e.st || read_data !== e.rd || page_is_erased !== e.pe
                    || last !== e.lst)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d rd=%h pe=%b last=%b, got st=%0d rd=%h pe=%b last=%b",
                                 e.st, e.rd, e.pe, e.lst, status, read_data, page_is_erased, last);
                end
            end
            if ($urandom_range(0, 40) == 0) out_calm = ~out_calm;
            out_wait = out_calm ? 0 : $urandom_range(0, 10);
        end
        else if (out_wait > 0)
            out_wait--;
        out_stall <= long_hold || (out_wait > 0);
    end

    // hold off the receiver for a long stretch once the stream is busy
    initial
    begin
        wait (accepted >= 60);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (600) @(posedge clk);
        long_hold <= 1'b0;
    end

    function automatic void add_req(logic [2:0] op, logic [15:0] addr, logic [15:0] len,
                                    logic [7:0] wb, logic st, logic en);
        flash_req_t r;
        r.op = op; r.addr = addr; r.len = len; r.wb = wb; r.st = st; r.en = en;
        pend_q.push_back(r);
    endfunction

    // one write access, mostly well formed; returns the number of items queued
    function automatic int add_write_access();
        int unsigned u, total, len, addr, n, kind;
        logic drop_end;
        u = unit_size();
        total = bytes_per_page() * pages_used();
        kind = $urandom_range(0, 9);
        len = ($urandom_range(0, 15) == 0) ? 0 : u * $urandom_range(1, 4);
        addr = (total >= len) ? ($urandom_range(0, total - len) & ~(u - 1)) : 0;
        n = len;
        drop_end = 1'b0;
        if (kind == 7) addr = addr | $urandom_range(1, u - 1);
        if (kind == 8) addr = (total > u) ? total - u / 2 : $urandom_range(total, 65535);
        if (kind == 9)
        begin
            if ($urandom_range(0, 1)) n = len + 2;
            else begin n = len / 2; drop_end = 1'b1; end
        end
        if (n == 0) n = 1;
        for (int unsigned i = 0; i < n; i++)
            add_req(OP_WRITE, addr[15:0], len[15:0],
                    $urandom_range(0, 2) == 0 ? 8'hFF << $urandom_range(0, 7) : 8'($urandom),
                    i == 0, i == n - 1 && !drop_end);
        return n;
    endfunction

    function automatic int add_random_request();
        int unsigned total, pick;
        total = bytes_per_page() * pages_used();
        pick = $urandom_range(0, 99);
        if (pick < 55) return add_write_access();
        if (pick < 75)
            add_req(OP_READ, 16'($urandom_range(0, total - 1)), 16'($urandom_range(0, 80)),
                    8'($urandom), 1'b0, 1'b0);
        else if (pick < 79) add_req(OP_ERASE_PAGE, 16'($urandom_range(0, 17)), 16'($urandom),
                                    8'h00, 1'b0, 1'b0);
        else if (pick < 82) add_req(OP_ERASE_SECTOR, 16'($urandom_range(0, total + 64)), 16'h0,
                                    8'h00, 1'b0, 1'b0);
        else if (pick < 86) add_req(OP_QUERY, 16'($urandom_range(0, 17)), 16'h0, 8'h00,
                                    1'b0, 1'b0);
        else if (pick < 87) add_req(OP_ERASE_ALL, 16'($urandom), 16'h0, 8'h00, 1'b0, 1'b0);
        else add_req(3'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                     1'($urandom), 1'($urandom));
        return 1;
    endfunction

    task automatic drain();
        while (pend_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [12:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PAGE_BYTES: pb_reg = value;
            CFG_PAGES:      pg_reg = value[4:0];
            CFG_WRITE_UNIT: unit_reg = value[1:0];
            default:        ae_reg = value[0];
        endcase
    endtask

    task automatic set_mode(logic [12:0] pb, logic [4:0] pg, logic [1:0] wu, logic ae);
        write_reg(CFG_PAGE_BYTES, pb);
        write_reg(CFG_PAGES, {8'h00, pg});
        write_reg(CFG_WRITE_UNIT, {11'h0, wu});
        write_reg(CFG_AUTO_ERASE, {12'h0, ae});
    endtask

    initial
    begin
        logic [12:0] pb_set [6] = '{13'd16, 13'd0, 13'd64, 13'd8191, 13'd13, 13'd4096};
        logic [4:0]  pg_set [6] = '{5'd4, 5'd0, 5'd8, 5'd31, 5'd16, 5'd1};
        logic [1:0]  wu_set [6] = '{2'd1, 2'd3, 2'd2, 2'd0, 2'd1, 2'd2};
        logic        ae_set [6] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
        int          count;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        set_mode(13'd4096, 5'd16, 2'd0, 1'b0);

        add_req(OP_READ, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0);
        add_req(OP_READ, 16'hFFFF, 16'h0001, 8'h00, 1'b0, 1'b0);
        add_req(OP_READ, 16'hFFFF, 16'h0002, 8'h00, 1'b0, 1'b0);
        add_req(OP_QUERY, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0);
        add_req(OP_WRITE, 16'h0000, 16'h0004, 8'hA5, 1'b1, 1'b0);
        add_req(OP_WRITE, 16'h0000, 16'h0004, 8'h00, 1'b0, 1'b0);
        add_req(OP_WRITE, 16'h0000, 16'h0004, 8'hFF, 1'b0, 1'b0);
        add_req(OP_WRITE, 16'h0000, 16'h0004, 8'h3C, 1'b0, 1'b1);
        add_req(OP_READ, 16'h0000, 16'd100, 8'h00, 1'b0, 1'b0);
        add_req(OP_QUERY, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0);
        // needs a 0 to 1 change: access fails, the next byte is dropped
        add_req(OP_WRITE, 16'h0000, 16'h0004, 8'hFF, 1'b1, 1'b0);
        add_req(OP_WRITE, 16'h0000, 16'h0004, 8'h00, 1'b0, 1'b1);
        add_req(OP_WRITE, 16'h0040, 16'h0004, 8'h00, 1'b0, 1'b1);
        add_req(OP_WRITE, 16'h0002, 16'h0004, 8'h00, 1'b1, 1'b1);
        add_req(OP_WRITE, 16'hFFFC, 16'h0008, 8'h00, 1'b1, 1'b1);
        add_req(OP_WRITE, 16'h0010, 16'h0000, 8'h00, 1'b1, 1'b1);
        add_req(OP_WRITE, 16'h0020, 16'h0004, 8'h12, 1'b1, 1'b0);
        add_req(OP_ERASE_PAGE, 16'h0001, 16'h0000, 8'h00, 1'b0, 1'b0);
        add_req(OP_WRITE, 16'h0040, 16'h0004, 8'h34, 1'b1, 1'b1);
        add_req(OP_ERASE_PAGE, 16'd16, 16'h0000, 8'h00, 1'b0, 1'b0);
        add_req(OP_ERASE_SECTOR, 16'd8192, 16'h0000, 8'h00, 1'b0, 1'b0);
        add_req(OP_QUERY, 16'd16, 16'h0000, 8'h00, 1'b0, 1'b0);
        add_req(OP_ERASE_ALL, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0);
        add_req(OP_SPARE6, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
        add_req(OP_SPARE7, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            set_mode(pb_set[ph], pg_set[ph], wu_set[ph], ae_set[ph]);
            count = 0;
            while (count < 42) count += add_random_request();
            drain();
        end

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/fam_pkg.sv
rtl/fam_ram.sv
rtl/fam_datapath.sv
rtl/fam_ctrl.sv
rtl/flash_array_model_unit.sv
tb/tb_flash_array_model_unit.sv
